>>> design/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Types and constants shared by the readout frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

  // Sync bytes at the start of every frame
  localparam logic [7:0] SYNC_BYTE0 = 8'hac;
  localparam logic [7:0] SYNC_BYTE1 = 8'h0f;
  // Flag kept in the held byte once both sync bytes matched
  localparam logic [7:0] SYNC_OK    = 8'h01;

  // Id word masks
  localparam logic [7:0] BOARD_MASK   = 8'h3e;
  localparam logic [7:0] CHANNEL_MASK = 8'h7f;
  localparam logic [7:0] RTYPE_MASK   = 8'hc0;

  // Result kinds (tuser)
  localparam logic RES_SAMPLE    = 1'b0;
  localparam logic RES_SYNC_ERR  = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ENDING = 2'd1,
    KIND_HEADER = 2'd2,
    KIND_BAD    = 2'd3
  } frame_kind_e;

  typedef struct packed {
    logic        kind;
    logic [11:0] sample_value;
    logic [8:0]  sample_index;
    logic [4:0]  board;
    logic [1:0]  chip;
    logic [6:0]  channel;
    logic [13:0] signal_id;
    logic [31:0] event_id;
    logic [47:0] event_time;
    logic [1:0]  readout_type;
    logic        last_of_frame;
  } rfd_result_t;

endpackage

`default_nettype wire

>>> design/readout_frame_deframer.sv
// ----------------------------------------------------------------------------
// readout_frame_deframer
// Splits a readout byte stream into frames; one result per sample or sync error.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one raw byte per transfer. Frames open with the sync
// bytes AC 0F; the third byte carries the frame type. Ending frames are
// skipped, event headers update the latched time, event id and readout type,
// data frames give one output transfer per twelve-bit sample.
// Output stream (m_axis): tdata carries the sample and its frame context,
// tuser is the result kind (0 sample, 1 sync error), tlast marks the final
// sample of a data frame. After a sync error one error transfer is sent and
// the block hunts chunk by chunk for the next event header.
// A result appears on m_axis in the cycle after the byte that completes it is
// taken. Throughput: one byte per cycle unless a held result waits on m_axis;
// the position counter and the field latches update as each byte is taken, so no byte waits on another.
// A byte is taken whenever the result register is empty or draining, so
// s_axis_tready_o follows m_axis_tready_i while a result is held.
// Reset clears the frame position, hunting flag and all latches; the first
// byte after reset is taken as the start of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module readout_frame_deframer import rfd_pkg::*; #(
  parameter int CHUNK_BYTES  = 4,
  parameter int HEADER_BYTES = 20,
  parameter int ENDING_BYTES = 8,
  parameter int DATA_BYTES   = 1036,
  parameter int SAMPLE_START = 6,
  parameter int SAMPLES      = 512
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // Input byte stream
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire logic [7:0]    s_axis_tdata_i,   // [7:0] data_byte
  // Result stream
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  // [11:0] sample_value, [20:12] sample_index, [25:21] board, [27:26] chip,
  // [34:28] channel, [48:35] signal_id, [80:49] event_id,
  // [128:81] event_time, [130:129] readout_type, [135:131] zero
  output logic [135:0]       m_axis_tdata_o,
  output logic               m_axis_tuser_o,   // [0] kind
  output logic               m_axis_tlast_o    // last_of_frame
);

  logic        accept;
  logic        res_valid;
  rfd_result_t res;
  rfd_result_t out_res;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  rfd_parser #(
    .CHUNK_BYTES  (CHUNK_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .ENDING_BYTES (ENDING_BYTES),
    .DATA_BYTES   (DATA_BYTES),
    .SAMPLE_START (SAMPLE_START),
    .SAMPLES      (SAMPLES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (accept),
    .byte_i       (s_axis_tdata_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Result register; also gates input so no byte is taken without room
  rfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {5'd0,
                           out_res.readout_type,
                           out_res.event_time,
                           out_res.event_id,
                           out_res.signal_id,
                           out_res.channel,
                           out_res.chip,
                           out_res.board,
                           out_res.sample_index,
                           out_res.sample_value};
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tlast_o = out_res.last_of_frame;

endmodule

`default_nettype wire

>>> design/rfd_parser.sv
// ----------------------------------------------------------------------------
// rfd_parser
// Frame position counter, sync check, header latches and sample assembly.
// One byte per cycle, at most one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_parser import rfd_pkg::*; #(
  parameter int CHUNK_BYTES  = 4,
  parameter int HEADER_BYTES = 20,
  parameter int ENDING_BYTES = 8,
  parameter int DATA_BYTES   = 1036,
  parameter int SAMPLE_START = 6,
  parameter int SAMPLES      = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        byte_valid_i,
  input  wire logic [7:0]  byte_i,
  output logic             res_valid_o,
  output rfd_result_t      res_o
);

  // Frame lengths, never shorter than a chunk
  localparam int LEN_CHUNK  = CHUNK_BYTES;
  localparam int LEN_DATA   = (DATA_BYTES < CHUNK_BYTES) ? CHUNK_BYTES : DATA_BYTES;
  localparam int LEN_ENDING = (ENDING_BYTES < CHUNK_BYTES) ? CHUNK_BYTES : ENDING_BYTES;
  localparam int LEN_HEADER = (HEADER_BYTES < CHUNK_BYTES) ? CHUNK_BYTES : HEADER_BYTES;

  logic [10:0]  pos_q, pos_d;
  frame_kind_e  kind_q, kind_d;
  logic         hunting_q, hunting_d;
  logic [31:0]  event_id_q, event_id_d;
  logic [47:0]  event_time_q, event_time_d;
  logic [1:0]   rtype_q, rtype_d;
  logic [15:0]  id_word_q, id_word_d;
  logic [7:0]   held_q, held_d;

  logic [11:0]  pos_inc;
  logic [11:0]  frame_len;
  logic [2:0]   ftype;
  logic [10:0]  rel;
  logic [9:0]   idx;
  logic [7:0]   id_hi, id_lo;
  logic [4:0]   board;
  logic [1:0]   chip;
  logic [6:0]   channel;
  logic [13:0]  signal_id;

  assign pos_inc = {1'b0, pos_q} + 12'd1;
  assign ftype   = byte_i[7:5];
  assign rel     = pos_q - 11'(SAMPLE_START);
  assign idx     = rel[10:1];

  // Id word fields; signal id = board*272 + chip*68 + channel
  assign id_hi     = id_word_q[15:8];
  assign id_lo     = id_word_q[7:0];
  assign board     = 5'((id_hi & BOARD_MASK) >> 1);
  assign chip      = {id_hi[0], id_lo[7]};
  assign channel   = 7'(id_lo & CHANNEL_MASK);
  assign signal_id = (14'(board) << 8) + (14'(board) << 4)
                   + (14'(chip) << 6) + (14'(chip) << 2) + 14'(channel);

  always_comb begin
    pos_d        = pos_q;
    kind_d       = kind_q;
    hunting_d    = hunting_q;
    event_id_d   = event_id_q;
    event_time_d = event_time_q;
    rtype_d      = rtype_q;
    id_word_d    = id_word_q;
    held_d       = held_q;
    res_valid_o  = 1'b0;

    res_o               = '0;
    res_o.event_id      = event_id_q;
    res_o.event_time    = event_time_q;
    res_o.readout_type  = rtype_q;

    if (pos_q == 11'd0) begin
      held_d = byte_i;
    end else if (pos_q == 11'd1) begin
      held_d = (held_q == SYNC_BYTE0 && byte_i == SYNC_BYTE1) ? SYNC_OK : 8'h00;
    end else if (pos_q == 11'd2) begin
      if (held_q != SYNC_OK)   kind_d = KIND_BAD;
      else if (hunting_q)      kind_d = ftype[1] ? KIND_HEADER : KIND_BAD;
      else if (ftype[0])       kind_d = KIND_ENDING;
      else if (ftype[1])       kind_d = KIND_HEADER;
      else                     kind_d = KIND_DATA;
    end else if (kind_q == KIND_HEADER) begin
      case (pos_q)
        11'd5:   rtype_d = 2'((byte_i & RTYPE_MASK) >> 6);
        11'd6:   event_time_d[15:8]  = byte_i;
        11'd7:   event_time_d[7:0]   = byte_i;
        11'd8:   event_time_d[31:24] = byte_i;
        11'd9:   event_time_d[23:16] = byte_i;
        11'd10:  event_time_d[47:40] = byte_i;
        11'd11:  event_time_d[39:32] = byte_i;
        11'd12:  event_id_d[15:8]    = byte_i;
        11'd13:  event_id_d[7:0]     = byte_i;
        11'd14:  event_id_d[31:24]   = byte_i;
        11'd15:  event_id_d[23:16]   = byte_i;
        default: ;
      endcase
    end else if (kind_q == KIND_DATA && !hunting_q) begin
      if (pos_q == 11'd4) begin
        id_word_d[15:8] = byte_i;
      end else if (pos_q == 11'd5) begin
        id_word_d[7:0] = byte_i;
      end else if (pos_q >= 11'(SAMPLE_START) && {1'b0, pos_q} < 12'(DATA_BYTES)
                   && idx < 10'(SAMPLES)) begin
        if (!rel[0]) begin
          held_d = byte_i;
        end else begin
          res_valid_o         = 1'b1;
          res_o.kind          = RES_SAMPLE;
          res_o.sample_value  = {held_q[3:0], byte_i};
          res_o.sample_index  = idx[8:0];
          res_o.board         = board;
          res_o.chip          = chip;
          res_o.channel       = channel;
          res_o.signal_id     = signal_id;
          res_o.last_of_frame = (idx == 10'(SAMPLES - 1));
        end
      end
    end

    // Frame length follows the kind just decided, with the hunting flag as it was
    if (hunting_q && kind_d != KIND_HEADER) begin
      frame_len = 12'(LEN_CHUNK);
    end else begin
      case (kind_d)
        KIND_DATA:   frame_len = 12'(LEN_DATA);
        KIND_ENDING: frame_len = 12'(LEN_ENDING);
        KIND_HEADER: frame_len = 12'(LEN_HEADER);
        default:     frame_len = 12'(LEN_CHUNK);
      endcase
    end

    if (pos_q >= 11'd2 && pos_inc >= frame_len) begin
      if (kind_d == KIND_BAD && !hunting_q) begin
        res_valid_o = 1'b1;
        res_o.kind  = RES_SYNC_ERR;
        hunting_d   = 1'b1;
      end else if (kind_d == KIND_HEADER && hunting_q) begin
        hunting_d = 1'b0;
      end
      pos_d = '0;
    end else begin
      pos_d = pos_inc[10:0];
    end

    res_valid_o = res_valid_o & byte_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      kind_q       <= KIND_DATA;
      hunting_q    <= 1'b0;
      event_id_q   <= '0;
      event_time_q <= '0;
      rtype_q      <= '0;
      id_word_q    <= '0;
      held_q       <= '0;
    end else if (byte_valid_i) begin
      pos_q        <= pos_d;
      kind_q       <= kind_d;
      hunting_q    <= hunting_d;
      event_id_q   <= event_id_d;
      event_time_q <= event_time_d;
      rtype_q      <= rtype_d;
      id_word_q    <= id_word_d;
      held_q       <= held_d;
    end
  end

endmodule

`default_nettype wire

>>> design/rfd_out_reg.sv
// ----------------------------------------------------------------------------
// rfd_out_reg
// Result register on the output stream; takes a new result whenever it is
// empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_out_reg import rfd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire rfd_result_t  in_data_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output rfd_result_t       out_data_o,
  input  wire logic         out_ready_i
);

  logic        valid_q;
  rfd_result_t data_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire
